// File: rtl/core/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the triangle plane projection block.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // plane axis components: signed, 30 fraction bits, range [-2^30, 2^30]
    localparam int UNIT_FRAC = 30;
    localparam int AXIS_W    = 32;
    localparam int AXIS_NUM  = 6;

    // dot product accumulator wraps at 64 bits
    localparam int ACC_W = 64;

    // helper axis switch: 100*dx^2 > 81*|d|^2, i.e. |x| > 0.9
    localparam int SEL_NUM = 100;
    localparam int SEL_DEN = 81;

    // configuration register indexes
    localparam logic [1:0] CFG_DIR_X = 2'd0;
    localparam logic [1:0] CFG_DIR_Y = 2'd1;
    localparam logic [1:0] CFG_DIR_Z = 2'd2;

    // J components at 0..2, K components at 3..5
    typedef logic [AXIS_NUM-1:0][AXIS_W-1:0] axis_set_t;

    typedef struct packed {
        logic busy;
        logic dir_zero;
    } tpp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_PROD,
        ST_LOAD,
        ST_NORM,
        ST_ROOT,
        ST_SETUP,
        ST_DIV,
        ST_STORE
    } axis_state_t;

endpackage

// File: rtl/core/tpp_axis_gen.sv
// ----------------------------------------------------------------------------
// tpp_axis_gen
// Sequencer that derives the two unit plane axes from the direction vector
// with a shared square root and a restoring divider.
// ----------------------------------------------------------------------------
module tpp_axis_gen
    import tpp_pkg::*;
#(
    parameter int DIR_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  logic signed [DIR_WIDTH-1:0] dir_x,
    input  logic signed [DIR_WIDTH-1:0] dir_y,
    input  logic signed [DIR_WIDTH-1:0] dir_z,
    output axis_set_t                   axis,
    output tpp_status_t                 status
);

    localparam int SQ_W   = 2 * DIR_WIDTH;
    localparam int N_W    = SQ_W + 2;
    localparam int SEL_W  = SQ_W + 7;
    localparam int Q_W    = 64;
    localparam int SH_W   = 6;
    localparam int DIV_W  = 34;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(AXIS_NUM - 1);
    localparam logic [IDX_W-1:0] IDX_K0    = IDX_W'(3);
    localparam logic [Q_W-1:0]   ROOT_BIT0 = Q_W'(1) << 60;
    localparam logic [Q_W-1:0]   UNIT_ONE  = Q_W'(1) << UNIT_FRAC;

    axis_state_t state_reg, state_next;

    logic        [SQ_W-1:0]  sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [SQ_W-1:0]  dxy_reg, dxz_reg, dyz_reg;
    logic        [SQ_W-1:0]  d2_reg, s2_reg;
    logic                    sel_y_reg, dir_zero_reg;
    logic        [Q_W-1:0]   p_reg;
    logic        [IDX_W-1:0] idx_reg;
    logic        [Q_W-1:0]   q_reg;
    logic        [SH_W-1:0]  sh_reg;
    logic        [N_W-1:0]   mag_reg;
    logic                    neg_reg;
    logic        [Q_W-1:0]   root_reg, bit_reg;
    logic        [DIV_W-1:0] rem_reg, div_reg;
    logic        [Q_W-1:0]   num_reg;
    logic        [CNT_W-1:0] cnt_reg;
    axis_set_t               axis_reg;

    logic        [SQ_W-1:0]  d2_sum, s2_sum;
    logic                    sel_y;
    logic signed [N_W-1:0]   n_sel;
    logic        [Q_W-1:0]   p_sel;
    logic        [Q_W-1:0]   root_try;
    logic        [DIV_W-1:0] rem_shift;
    logic        [Q_W-1:0]   r_clamp;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        if (restart)
        begin
            state_next = ST_SQUARE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:   state_next = ST_IDLE;
                ST_SQUARE: state_next = ST_SUM;
                ST_SUM:    state_next = ST_PROD;
                ST_PROD:   state_next = ST_LOAD;
                ST_LOAD:   state_next = ST_NORM;
                ST_NORM:
                begin
                    if (q_reg == '0)
                        state_next = ST_STORE;
                    else if (q_reg[63:62] == 2'b00 && q_reg[61:60] != 2'b00)
                        state_next = ST_ROOT;
                end
                ST_ROOT:   state_next = bit_reg[0] ? ST_SETUP : ST_ROOT;
                ST_SETUP:  state_next = ST_DIV;
                ST_DIV:    state_next = (cnt_reg == '1) ? ST_STORE : ST_DIV;
                ST_STORE:  state_next = (idx_reg == IDX_LAST) ? ST_IDLE : ST_LOAD;
                default:   state_next = ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        status.busy     = (state_reg != ST_IDLE);
        status.dir_zero = dir_zero_reg;
        axis            = axis_reg;
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    always_comb
    begin
        d2_sum = sq_x_reg + sq_y_reg + sq_z_reg;
        sel_y  = (SEL_W'(SEL_NUM) * SEL_W'(sq_x_reg)) > (SEL_W'(SEL_DEN) * SEL_W'(d2_sum));
        s2_sum = sel_y ? (sq_x_reg + sq_z_reg) : (sq_y_reg + sq_z_reg);
    end

    always_comb
    begin
        p_sel = (idx_reg < IDX_K0) ? Q_W'(s2_reg) : p_reg;
        n_sel = '0;
        if (sel_y_reg)
        begin
            unique case (idx_reg)
                3'd0:    n_sel = -N_W'(dir_z);
                3'd1:    n_sel = '0;
                3'd2:    n_sel = N_W'(dir_x);
                3'd3:    n_sel = N_W'(dxy_reg);
                3'd4:    n_sel = -$signed({2'b00, s2_reg});
                3'd5:    n_sel = N_W'(dyz_reg);
                default: n_sel = '0;
            endcase
        end
        else
        begin
            unique case (idx_reg)
                3'd0:    n_sel = '0;
                3'd1:    n_sel = N_W'(dir_z);
                3'd2:    n_sel = -N_W'(dir_y);
                3'd3:    n_sel = -$signed({2'b00, s2_reg});
                3'd4:    n_sel = N_W'(dxy_reg);
                3'd5:    n_sel = N_W'(dxz_reg);
                default: n_sel = '0;
            endcase
        end
    end

    always_comb
    begin
        root_try  = root_reg + bit_reg;
        rem_shift = {rem_reg[DIV_W-2:0], num_reg[Q_W-1]};
        r_clamp   = (num_reg > UNIT_ONE) ? UNIT_ONE : num_reg;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SQUARE;
            dir_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM && !restart)
                dir_zero_reg <= (d2_sum == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SQUARE:
            begin
                sq_x_reg <= SQ_W'(dir_x * dir_x);
                sq_y_reg <= SQ_W'(dir_y * dir_y);
                sq_z_reg <= SQ_W'(dir_z * dir_z);
                dxy_reg  <= dir_x * dir_y;
                dxz_reg  <= dir_x * dir_z;
                dyz_reg  <= dir_y * dir_z;
            end
            ST_SUM:
            begin
                d2_reg    <= d2_sum;
                s2_reg    <= s2_sum;
                sel_y_reg <= sel_y;
            end
            ST_PROD:
            begin
                p_reg   <= Q_W'(d2_reg) * Q_W'(s2_reg);
                idx_reg <= '0;
            end
            ST_LOAD:
            begin
                q_reg   <= p_sel;
                sh_reg  <= SH_W'(31);
                neg_reg <= n_sel[N_W-1];
                mag_reg <= n_sel[N_W-1] ? N_W'(-n_sel) : N_W'(n_sel);
            end
            ST_NORM:
            begin
                if (q_reg == '0)
                begin
                    num_reg <= '0;
                end
                else if (q_reg[63:62] != 2'b00)
                begin
                    q_reg  <= q_reg >> 2;
                    sh_reg <= SH_W'(30);
                end
                else if (q_reg[61:60] == 2'b00)
                begin
                    q_reg  <= q_reg << 2;
                    sh_reg <= sh_reg + SH_W'(1);
                end
                else
                begin
                    root_reg <= '0;
                    bit_reg  <= ROOT_BIT0;
                end
            end
            ST_ROOT:
            begin
                if (q_reg >= root_try)
                begin
                    q_reg    <= q_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_SETUP:
            begin
                // root lies in [2^30, 2^31)
                num_reg <= (Q_W'(mag_reg) << sh_reg) + root_reg;
                div_reg <= DIV_W'({root_reg, 1'b0});
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_shift >= div_reg)
                begin
                    rem_reg <= rem_shift - div_reg;
                    num_reg <= {num_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    num_reg <= {num_reg[Q_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_STORE:
            begin
                axis_reg[idx_reg] <= neg_reg ? AXIS_W'(-r_clamp) : AXIS_W'(r_clamp);
                idx_reg           <= idx_reg + IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/triangle_plane_projection_top.sv
// ----------------------------------------------------------------------------
// triangle_plane_projection_top
// Orthographic projection of triangles onto the plane normal to a direction.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write dir_x/dir_y/dir_z through wr_en/wr_index/wr_data.
//   Each write (and reset) starts the axis sequencer, which holds busy high
//   while it forms the two unit axes (normalize, 31-step square root and
//   64-step divide for each of six components).
//   Input: one triangle transaction is taken on each clock where start is
//   high and busy is low; with busy low a triangle may enter every cycle.
//   Output: done pulses for one cycle with b_u/b_v/c_u/c_v/direction_zero,
//   once the triangle has passed the stages below, in order, one per triangle.
//   The five stages are offset subtract, multiply, sum, round, saturate.
//   The receiver cannot stall; results are never held back.
//   Reset clears the pipeline, loads the default direction (+x) and runs
//   the axis sequencer once before busy drops.
// ----------------------------------------------------------------------------
module triangle_plane_projection_top
    import tpp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int DIR_WIDTH   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          wr_en,
    input  logic [1:0]                    wr_index,
    input  logic [DIR_WIDTH-1:0]          wr_data,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    output logic signed [COORD_WIDTH-1:0] b_u,
    output logic signed [COORD_WIDTH-1:0] b_v,
    output logic signed [COORD_WIDTH-1:0] c_u,
    output logic signed [COORD_WIDTH-1:0] c_v,
    output logic                          direction_zero
);

    localparam int REL_W  = COORD_WIDTH + 1;
    localparam int PROD_W = REL_W + AXIS_W;
    localparam int RND_W  = ACC_W + 1 - UNIT_FRAC;
    localparam int CMP_W  = ACC_W + 1;
    localparam logic [CMP_W-1:0] SAT_NEG  = CMP_W'(1) << (COORD_WIDTH - 1);
    localparam logic [CMP_W-1:0] SAT_POS  = SAT_NEG - CMP_W'(1);
    localparam logic [CMP_W-1:0] RND_HALF = CMP_W'(1) << (UNIT_FRAC - 1);
    localparam logic [DIR_WIDTH-1:0] DIR_X_RST = DIR_WIDTH'(16384);

    logic signed [DIR_WIDTH-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    axis_set_t                   axis;
    tpp_status_t                 status;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic signed [REL_W-1:0]       rel_reg [2][3];
    logic signed [PROD_W-1:0]      prod_reg [4][3];
    logic signed [ACC_W-1:0]       sum_reg [4];
    logic                          neg_reg [4];
    logic        [RND_W-1:0]       rnd_reg [4];
    logic signed [COORD_WIDTH-1:0] res_reg [4];
    logic                          dz_out_reg;
    logic                          accept;

    assign accept = start && !status.busy;
    assign busy   = status.busy;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= DIR_X_RST;
            dir_y_reg <= '0;
            dir_z_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_DIR_X: dir_x_reg <= wr_data;
                CFG_DIR_Y: dir_y_reg <= wr_data;
                CFG_DIR_Z: dir_z_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    tpp_axis_gen #(
        .DIR_WIDTH (DIR_WIDTH)
    ) u_axis_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (wr_en),
        .dir_x   (dir_x_reg),
        .dir_y   (dir_y_reg),
        .dir_z   (dir_z_reg),
        .axis    (axis),
        .status  (status)
    );

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        // stage 1: offsets from vertex a
        rel_reg[0][0] <= REL_W'(b_x) - REL_W'(a_x);
        rel_reg[0][1] <= REL_W'(b_y) - REL_W'(a_y);
        rel_reg[0][2] <= REL_W'(b_z) - REL_W'(a_z);
        rel_reg[1][0] <= REL_W'(c_x) - REL_W'(a_x);
        rel_reg[1][1] <= REL_W'(c_y) - REL_W'(a_y);
        rel_reg[1][2] <= REL_W'(c_z) - REL_W'(a_z);

        // stage 2: products; order b.J, b.K, c.J, c.K
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[0][k] <= rel_reg[0][k] * $signed(axis[k]);
            prod_reg[1][k] <= rel_reg[0][k] * $signed(axis[k+3]);
            prod_reg[2][k] <= rel_reg[1][k] * $signed(axis[k]);
            prod_reg[3][k] <= rel_reg[1][k] * $signed(axis[k+3]);
        end

        // stage 3: dot products, wrapping at 64 bits
        for (int o = 0; o < 4; o++)
        begin
            sum_reg[o] <= ACC_W'(prod_reg[o][0]) + ACC_W'(prod_reg[o][1])
                        + ACC_W'(prod_reg[o][2]);
        end

        // stage 4: magnitude, round half away from zero
        for (int o = 0; o < 4; o++)
        begin
            neg_reg[o] <= sum_reg[o][ACC_W-1];
            rnd_reg[o] <= RND_W'(((sum_reg[o][ACC_W-1] ? CMP_W'(-sum_reg[o])
                                                     : CMP_W'(sum_reg[o]))
                                  + RND_HALF) >> UNIT_FRAC);
        end

        // stage 5: saturate, restore sign; zero when the direction is zero
        for (int o = 0; o < 4; o++)
        begin
            if (status.dir_zero)
                res_reg[o] <= '0;
            else if (neg_reg[o])
                res_reg[o] <= COORD_WIDTH'(-((CMP_W'(rnd_reg[o]) > SAT_NEG) ? SAT_NEG
                                                                         : CMP_W'(rnd_reg[o])));
            else
                res_reg[o] <= COORD_WIDTH'((CMP_W'(rnd_reg[o]) > SAT_POS) ? SAT_POS
                                                                        : CMP_W'(rnd_reg[o]));
        end
        dz_out_reg <= status.dir_zero;
    end

    assign done           = done_reg;
    assign b_u            = res_reg[0];
    assign b_v            = res_reg[1];
    assign c_u            = res_reg[2];
    assign c_v            = res_reg[3];
    assign direction_zero = dz_out_reg;

endmodule
